// ===== hdl/two_segment_transit_timer_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Two-segment transit timer: assertion macros
// Check macros shared by the RTL files; they compile away under synthesis.
// ---------------------------------------------------------------------------
`ifndef TWO_SEGMENT_TRANSIT_TIMER_UNIT_DEFINES_SVH
`define TWO_SEGMENT_TRANSIT_TIMER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define TSTT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");
// Expression must never be true outside reset.
`define TSTT_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");
`else
`define TSTT_ASSERT(lbl, clk, rst_n, prop)
`define TSTT_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ===== hdl/tstt_pkg.sv =====
// ---------------------------------------------------------------------------
// Two-segment transit timer: package
// Shared constants and the event bundle returned by each timestamp queue.
// ---------------------------------------------------------------------------
`default_nettype none

package tstt_pkg;

    localparam int          DEPTH_ONE_DEF = 16;
    localparam int          DEPTH_TWO_DEF = 16;
    localparam int          STAMP_W       = 32;
    localparam int          FILL_W        = 5;
    localparam int          PADDR_W       = 3;
    localparam logic [31:0] MAX_MS_RESET  = 32'd60000;

    // Register word index, taken from paddr above the byte offset
    localparam logic        REG_MAX_MS    = 1'b0;

    // Outcome of one queue update
    typedef struct packed {
        logic push_drop;   // push found the queue full
        logic pop_empty;   // pop found the queue empty
        logic popped;      // an entry was removed
        logic nonempty;    // queue holds entries after the update
    } tstt_evt_t;

endpackage

`default_nettype wire

// ===== hdl/two_segment_transit_timer_unit.sv =====
// ---------------------------------------------------------------------------
// Two-segment transit timer unit
// Sensor edges push and pop millisecond stamps in two queues; each item
// returns held travel times for both segments plus event flags and fills.
// ---------------------------------------------------------------------------
//  channel   dir  signals                     width  content
//  s_        in   tvalid tready tdata         40     now_ms, levels, befores
//  m_        out  tvalid tready tdata         80     times, flags, fills
//  config    in   APB psel..pready            32     max_ms at byte addr 0
//
//  Each item passes the states IDLE (accept plus head read), POP (queue
//  update with the new-head read), then HEAD (age compute into the output
//  register), as the two stamp memories have registered reads.
//  A new beat is taken as soon as the last one is in the output register.
//  Reset is synchronous: pointers, counts and held times clear, max_ms goes
//  to 60000. Stamp memories are not cleared; no pass runs after reset.
//  A full output register holds the unit in HEAD until m_tready drains it.
// ---------------------------------------------------------------------------
`default_nettype none
`include "two_segment_transit_timer_unit_defines.svh"

module two_segment_transit_timer_unit #(
    parameter int DEPTH_ONE = tstt_pkg::DEPTH_ONE_DEF,
    parameter int DEPTH_TWO = tstt_pkg::DEPTH_TWO_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // tdata: now_ms[31:0], level1[32], level2[33], level3[34],
    //        before1[35], before2[36], before3[37], zero pad[39:38]
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [39:0]                   s_tdata,
    // tdata: time_one_ms[31:0], time_two_ms[63:32], one_finished[64],
    //        two_finished[65], s1_push_dropped[66], s2_pop_empty[67],
    //        s2_push_dropped[68], s3_pop_empty[69], fill_one[74:70],
    //        fill_two[79:75]
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [79:0]                        m_tdata,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tstt_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import tstt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_POP  = 3'b010,
        ST_HEAD = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [31:0]        max_reg;
    logic [STAMP_W-1:0] now_reg;
    logic [2:0]         lvl_reg;
    logic [2:0]         rise_reg;
    logic [31:0]        held_one_reg, held_one_next;
    logic [31:0]        held_two_reg, held_two_next;
    tstt_evt_t          evt1_reg, evt2_reg;
    logic [79:0]        m_tdata_reg;
    logic               m_tvalid_reg;

    tstt_evt_t          evt1, evt2;
    logic [STAMP_W-1:0] pop1, pop2, head1, head2;
    logic [FILL_W-1:0]  fill1, fill2;
    logic               s_accept, out_free, out_load, cfg_wr;
    logic               idle1, idle2;

    // Age since a stamp, modulo 2^32, clipped at the ceiling
    function automatic logic [31:0] age_sat(input logic [31:0] now,
                                            input logic [31:0] then_ms,
                                            input logic [31:0] ceil);
        logic [31:0] d;
        d = now - then_ms;
        return (d > ceil) ? ceil : d;
    endfunction

    // -----------------------------------------------------------------
    // Configuration port: one register, zero wait states
    // -----------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_MS);
    assign prdata = (paddr[2] == REG_MAX_MS) ? max_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= MAX_MS_RESET;
        end else if (cfg_wr) begin
            max_reg <= pwdata;
        end
    end

    // -----------------------------------------------------------------
    // Sequencer
    // -----------------------------------------------------------------
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == ST_HEAD) && out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_POP;
                end
            end
            ST_POP: begin
                state_next = ST_HEAD;
            end
            ST_HEAD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Capture the beat; only rising edges and current levels matter later
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            now_reg  <= s_tdata[31:0];
            lvl_reg  <= s_tdata[34:32];
            rise_reg <= s_tdata[34:32] & ~s_tdata[37:35];
        end
    end

    // -----------------------------------------------------------------
    // Queues: S1 pushes q1, S2 pops q1 then pushes q2, S3 pops q2
    // -----------------------------------------------------------------
    tstt_fifo #(.DEPTH(DEPTH_ONE)) u_fifo_one (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .rd_head_i    (s_accept),
        .op_i         (state_reg == ST_POP),
        .push_req_i   (rise_reg[0]),
        .pop_req_i    (rise_reg[1]),
        .now_i        (now_reg),
        .evt_o        (evt1),
        .pop_stamp_o  (pop1),
        .head_stamp_o (head1),
        .fill_o       (fill1)
    );

    tstt_fifo #(.DEPTH(DEPTH_TWO)) u_fifo_two (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .rd_head_i    (s_accept),
        .op_i         (state_reg == ST_POP),
        .push_req_i   (rise_reg[1]),
        .pop_req_i    (rise_reg[2]),
        .now_i        (now_reg),
        .evt_o        (evt2),
        .pop_stamp_o  (pop2),
        .head_stamp_o (head2),
        .fill_o       (fill2)
    );

    // -----------------------------------------------------------------
    // Held times: finish on pop, then live head age, then idle clear
    // -----------------------------------------------------------------
    assign idle1 = !lvl_reg[0] && !lvl_reg[1] && !lvl_reg[2];
    assign idle2 = !lvl_reg[1] && !lvl_reg[2];

    always_comb begin
        held_one_next = held_one_reg;
        held_two_next = held_two_reg;
        if (state_reg == ST_POP) begin
            if (evt1.popped) begin
                held_one_next = age_sat(now_reg, pop1, max_reg);
            end
            if (evt2.popped) begin
                held_two_next = age_sat(now_reg, pop2, max_reg);
            end
        end else if (out_load) begin
            if (evt1.nonempty) begin
                held_one_next = age_sat(now_reg, head1, max_reg);
            end else if (idle1) begin
                held_one_next = '0;
            end
            if (evt2.nonempty) begin
                held_two_next = age_sat(now_reg, head2, max_reg);
            end else if (idle2) begin
                held_two_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_one_reg <= '0;
            held_two_reg <= '0;
        end else begin
            held_one_reg <= held_one_next;
            held_two_reg <= held_two_next;
        end
    end

    // Hold the update flags for the HEAD state
    always_ff @(posedge aclk) begin
        if (state_reg == ST_POP) begin
            evt1_reg <= evt1;
            evt2_reg <= evt2;
        end
    end

    // -----------------------------------------------------------------
    // Output register
    // -----------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {fill2, fill1,
                            evt2_reg.pop_empty, evt2_reg.push_drop,
                            evt1_reg.pop_empty, evt1_reg.push_drop,
                            evt2_reg.popped, evt1_reg.popped,
                            held_two_next, held_one_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `TSTT_ASSERT(a_accept_to_pop, aclk, aresetn, s_accept |=> (state_reg == ST_POP))
    `TSTT_ASSERT(a_pop_to_head, aclk, aresetn, (state_reg == ST_POP) |=> (state_reg == ST_HEAD))
    `TSTT_ASSERT(a_load_from_head, aclk, aresetn,
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_HEAD))

endmodule

`default_nettype wire

// ===== hdl/tstt_fifo.sv =====
// ---------------------------------------------------------------------------
// Two-segment transit timer: timestamp queue
// Circular buffer in a synchronous memory with registered reads, with forwarding of
// a stamp written in the same cycle that its slot becomes the head.
// ---------------------------------------------------------------------------
`default_nettype none
`include "two_segment_transit_timer_unit_defines.svh"

module tstt_fifo #(
    parameter int DEPTH = tstt_pkg::DEPTH_ONE_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           rd_head_i,
    input  wire logic                           op_i,
    input  wire logic                           push_req_i,
    input  wire logic                           pop_req_i,
    input  wire logic [tstt_pkg::STAMP_W-1:0]   now_i,
    output tstt_pkg::tstt_evt_t                 evt_o,
    output logic      [tstt_pkg::STAMP_W-1:0]   pop_stamp_o,
    output logic      [tstt_pkg::STAMP_W-1:0]   head_stamp_o,
    output logic      [tstt_pkg::FILL_W-1:0]    fill_o
);
    import tstt_pkg::*;

    localparam int             AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int             CW   = $clog2(DEPTH + 1);
    localparam logic [AW-1:0]  LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0]  FULL = CW'(DEPTH);

    logic [STAMP_W-1:0] mem [DEPTH];

    logic [AW-1:0]      head_reg, head_next, head_adv;
    logic [AW-1:0]      tail_reg, tail_next, tail_adv;
    logic [CW-1:0]      count_reg, count_next;
    logic [STAMP_W-1:0] rdata_reg;
    logic               fwd_reg;
    logic               push_ok, pop_ok;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;

    // Push precedes pop, so a pop on an empty queue can take the fresh push
    assign push_ok  = push_req_i && (count_reg != FULL);
    assign pop_ok   = pop_req_i && ((count_reg != '0) || push_ok);
    assign head_adv = (head_reg == LAST) ? '0 : head_reg + 1'b1;
    assign tail_adv = (tail_reg == LAST) ? '0 : tail_reg + 1'b1;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (op_i) begin
            if (pop_ok) begin
                head_next = head_adv;
            end
            if (push_ok) begin
                tail_next = tail_adv;
            end
            count_next = count_reg + CW'(push_ok) - CW'(pop_ok);
        end
    end

    // First read fetches the head for a pop, second fetches the new head
    assign rd_en   = rd_head_i || op_i;
    assign rd_addr = op_i ? head_next : head_reg;

    always_ff @(posedge aclk) begin
        if (op_i && push_ok) begin
            mem[tail_reg] <= now_i;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
        if (op_i) begin
            fwd_reg <= push_ok && (count_reg == CW'(pop_ok));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign pop_stamp_o  = (count_reg == '0) ? now_i : rdata_reg;
    assign head_stamp_o = fwd_reg ? now_i : rdata_reg;

    assign evt_o.push_drop = push_req_i && !push_ok;
    assign evt_o.pop_empty = pop_req_i && !pop_ok;
    assign evt_o.popped    = pop_ok;
    assign evt_o.nonempty  = (count_reg != '0);
    assign fill_o          = FILL_W'(count_reg);

    `TSTT_ASSERT_NEVER(a_count_bound, aclk, aresetn, count_reg > FULL)
    `TSTT_ASSERT(a_ptr_empty, aclk, aresetn, (count_reg == '0) |-> (head_reg == tail_reg))
    `TSTT_ASSERT(a_count_up, aclk, aresetn,
        (op_i && push_ok && !pop_ok) |=> (count_reg == $past(count_reg) + 1'b1))
    `TSTT_ASSERT(a_op_after_read, aclk, aresetn, op_i |-> $past(rd_head_i))

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Two-segment transit timer unit: testbench
// Streams sensor samples into the unit and predicts every report beat from
// a behavioral copy of both stamp queues and the held segment times. Each
// report is checked field by field. Both channels stall at random, and
// max_ms is swept between traffic phases.
// ---------------------------------------------------------------------------
module tb;
    import tstt_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 12;
    localparam int IDLE_LIMIT    = 4000;   // cycles with no beat on either side
    localparam int LONG_HOLD     = 300;    // report-side hold-off, in cycles
    localparam int SETTLE_CYCLES = 8;      // covers the IDLE, POP and HEAD steps
    localparam int MAX_REPORTS   = 10;
    localparam logic [PADDR_W-1:0] MAX_MS_ADDR = {REG_MAX_MS, 2'b00};

    // Input beat, last field in the lowest bits
    typedef struct packed {
        logic [1:0]  pad;
        logic        before3;
        logic        before2;
        logic        before1;
        logic        level3;
        logic        level2;
        logic        level1;
        logic [31:0] now_ms;
    } sample_t;

    // Report beat, last field in the lowest bits
    typedef struct packed {
        logic [FILL_W-1:0] fill_two;
        logic [FILL_W-1:0] fill_one;
        logic              s3_pop_empty;
        logic              s2_push_dropped;
        logic              s2_pop_empty;
        logic              s1_push_dropped;
        logic              two_finished;
        logic              one_finished;
        logic [31:0]       time_two_ms;
        logic [31:0]       time_one_ms;
    } report_t;

    // Tracks both stamp queues and the held times, and holds the reports
    // still owed by the unit in arrival order.
    class transit_scoreboard;
        logic [STAMP_W-1:0] stamps_one [DEPTH_ONE_DEF];
        logic [STAMP_W-1:0] stamps_two [DEPTH_TWO_DEF];
        int                 rd_one, wr_one, fill_one;
        int                 rd_two, wr_two, fill_two;
        logic [31:0]        held_one, held_two, max_ms;
        report_t            expected_reports[$];
        int                 fault_count;

        function new();
            rd_one      = 0;
            wr_one      = 0;
            fill_one    = 0;
            rd_two      = 0;
            wr_two      = 0;
            fill_two    = 0;
            held_one    = '0;
            held_two    = '0;
            max_ms      = MAX_MS_RESET;
            fault_count = 0;
        endfunction

        function logic [31:0] aged(logic [31:0] now_ms, logic [31:0] stamp);
            logic [31:0] span;
            span = now_ms - stamp;   // wraps modulo 2^32
            return (span > max_ms) ? max_ms : span;
        endfunction

        function void set_max_ms(logic [31:0] value);
            max_ms = value;
        endfunction

        function bit drained();
            return expected_reports.size() == 0;
        endfunction

        function void log_fault(string what);
            fault_count++;
            if (fault_count <= MAX_REPORTS) begin
                $display("[%0t] mismatch: %s", $time, what);
            end
        endfunction

        function void note_sample(sample_t s);
            report_t     r;
            logic [31:0] stamp;
            r = '0;
            // S1 rising edge: queue the stamp for segment one
            if (s.level1 && !s.before1) begin
                if (fill_one == DEPTH_ONE_DEF) begin
                    r.s1_push_dropped = 1'b1;
                end else begin
                    stamps_one[wr_one] = s.now_ms;
                    wr_one = (wr_one + 1) % DEPTH_ONE_DEF;
                    fill_one++;
                end
            end
            // S2 rising edge: finish segment one, then start segment two
            if (s.level2 && !s.before2) begin
                if (fill_one == 0) begin
                    r.s2_pop_empty = 1'b1;
                end else begin
                    stamp = stamps_one[rd_one];
                    rd_one = (rd_one + 1) % DEPTH_ONE_DEF;
                    fill_one--;
                    held_one = aged(s.now_ms, stamp);
                    r.one_finished = 1'b1;
                end
                if (fill_two == DEPTH_TWO_DEF) begin
                    r.s2_push_dropped = 1'b1;
                end else begin
                    stamps_two[wr_two] = s.now_ms;
                    wr_two = (wr_two + 1) % DEPTH_TWO_DEF;
                    fill_two++;
                end
            end
            // S3 rising edge: finish segment two
            if (s.level3 && !s.before3) begin
                if (fill_two == 0) begin
                    r.s3_pop_empty = 1'b1;
                end else begin
                    stamp = stamps_two[rd_two];
                    rd_two = (rd_two + 1) % DEPTH_TWO_DEF;
                    fill_two--;
                    held_two = aged(s.now_ms, stamp);
                    r.two_finished = 1'b1;
                end
            end
            // Live tracking overrides a just-finished time
            if (fill_one > 0) held_one = aged(s.now_ms, stamps_one[rd_one]);
            if (fill_two > 0) held_two = aged(s.now_ms, stamps_two[rd_two]);
            // Empty queue with quiet sensors clears the held time
            if (fill_one == 0 && !s.level1 && !s.level2 && !s.level3) held_one = '0;
            if (fill_two == 0 && !s.level2 && !s.level3) held_two = '0;

            r.time_one_ms = held_one;
            r.time_two_ms = held_two;
            r.fill_one    = FILL_W'(fill_one);
            r.fill_two    = FILL_W'(fill_two);
            expected_reports.push_back(r);
        endfunction

        function void check_report(report_t got);
            report_t want;
            string   bad;
            if (expected_reports.size() == 0) begin
                log_fault($sformatf("report beat with nothing pending: %h", got));
                return;
            end
            want = expected_reports.pop_front();
            bad  = "";
            if (got.time_one_ms     !== want.time_one_ms)     bad = {bad, " time_one_ms"};
            if (got.time_two_ms     !== want.time_two_ms)     bad = {bad, " time_two_ms"};
            if (got.one_finished    !== want.one_finished)    bad = {bad, " one_finished"};
            if (got.two_finished    !== want.two_finished)    bad = {bad, " two_finished"};
            if (got.s1_push_dropped !== want.s1_push_dropped) bad = {bad, " s1_push_dropped"};
            if (got.s2_pop_empty    !== want.s2_pop_empty)    bad = {bad, " s2_pop_empty"};
            if (got.s2_push_dropped !== want.s2_push_dropped) bad = {bad, " s2_push_dropped"};
            if (got.s3_pop_empty    !== want.s3_pop_empty)    bad = {bad, " s3_pop_empty"};
            if (got.fill_one        !== want.fill_one)        bad = {bad, " fill_one"};
            if (got.fill_two        !== want.fill_two)        bad = {bad, " fill_two"};
            if (bad != "") begin
                log_fault($sformatf("field(s)%s: expected %h, got %h", bad, want, got));
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [39:0]         s_tdata;    // now_ms, level1..3, before1..3, zero pad
    logic                m_tvalid;
    logic                m_tready;
    logic [79:0]         m_tdata;    // time_one_ms, time_two_ms, flags, fill_one, fill_two
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    transit_scoreboard   board;
    logic [31:0]         clock_ms;    // running sample time of well-formed traffic
    logic [2:0]          sensor_lv;   // last levels sent, bit 0 is S1
    bit                  gaps_off;    // no idling on either side
    bit                  hold_req;    // ask the receiver for one long hold-off
    int                  stall_cycles;

    two_segment_transit_timer_unit dut (.*);

    initial aclk = 1'b0;
    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Record every beat that moves, check reports, and watch for a hang.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) board.note_sample(sample_t'(s_tdata));
            if (m_tvalid && m_tready) board.check_report(report_t'(m_tdata));
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Report-side receiver: random short stalls, one long hold-off on request.
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                // Hold off long enough for the unit to back up into its input
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
            end else if (!gaps_off && $urandom_range(0, 99) < 30) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(0, 6)) @(negedge aclk);
            end
        end
    end

    // Offer one beat, with an optional idle burst ahead of it; return once taken.
    task automatic send_sample(input sample_t beat);
        int gap;
        if (!gaps_off && $urandom_range(0, 99) < 25) begin
            gap = $urandom_range(1, 3);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_levels(input logic [31:0] now_ms, input logic [2:0] lv,
                               input logic [2:0] bf);
        sample_t beat;
        beat = '0;
        beat.now_ms = now_ms;
        {beat.level3, beat.level2, beat.level1}    = lv;
        {beat.before3, beat.before2, beat.before1} = bf;
        send_sample(beat);
    endtask

    task automatic stop_samples();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        board.set_max_ms(data);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drain every owed report, let the pipeline settle, then rewrite max_ms.
    task automatic settle_then_write(input logic [31:0] value);
        stop_samples();
        while (!board.drained()) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        apb_write(MAX_MS_ADDR, value);
    endtask

    // Mostly well-formed sensor traces whose edge rates change every 25
    // beats, so the queues fill, overflow and drain; a few noise beats
    // break the trace with fully random fields.
    task automatic run_traffic(input int n_items, input int unsigned step_cap);
        sample_t     beat;
        int unsigned rate1, rate2, rate3;
        logic [2:0]  next_lv;
        rate1 = 30;
        rate2 = 30;
        rate3 = 30;
        for (int i = 0; i < n_items; i++) begin
            if (i % 25 == 0) begin
                case ($urandom_range(0, 4))
                    0: begin rate1 = 30; rate2 = 30; rate3 = 30; end   // balanced
                    1: begin rate1 = 70; rate2 = 10; rate3 = 10; end   // flood S1
                    2: begin rate1 = 10; rate2 = 70; rate3 = 10; end   // flood S2
                    3: begin rate1 = 10; rate2 = 30; rate3 = 70; end   // drain S3
                    default: begin rate1 = 5; rate2 = 5; rate3 = 5; end // quiet road
                endcase
            end
            beat = '0;
            if ($urandom_range(0, 99) < 8) begin
                beat.now_ms = $urandom;
                {beat.before3, beat.before2, beat.before1,
                 beat.level3, beat.level2, beat.level1} = 6'($urandom_range(0, 63));
            end else begin
                clock_ms = clock_ms + $urandom_range(0, step_cap);
                next_lv  = sensor_lv;
                if ($urandom_range(0, 99) < rate1) next_lv[0] = ~next_lv[0];
                if ($urandom_range(0, 99) < rate2) next_lv[1] = ~next_lv[1];
                if ($urandom_range(0, 99) < rate3) next_lv[2] = ~next_lv[2];
                beat.now_ms = clock_ms;
                {beat.level3, beat.level2, beat.level1}    = next_lv;
                {beat.before3, beat.before2, beat.before1} = sensor_lv;
                sensor_lv = next_lv;
            end
            send_sample(beat);
        end
    endtask

    initial begin
        board        = new();
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        clock_ms     = '0;
        sensor_lv    = '0;
        gaps_off     = 1'b0;
        hold_req     = 1'b0;
        stall_cycles = 0;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed beats at the reset ceiling of 60000 ms
        send_levels(32'd0,          3'b000, 3'b000);  // all quiet
        send_levels(32'hFFFF_FFFF,  3'b111, 3'b111);  // all present, no edges
        send_levels(32'd10,         3'b100, 3'b000);  // S3 finds segment two empty
        send_levels(32'd20,         3'b010, 3'b000);  // S2 finds segment one empty
        send_levels(32'd50,         3'b100, 3'b010);  // S3 finishes 30 ms
        send_levels(32'd100,        3'b111, 3'b000);  // rising edges on S1, S2 and S3 together
        send_levels(32'hFFFF_FFF0,  3'b001, 3'b000);  // stamp just before the wrap
        send_levels(32'd10,         3'b010, 3'b001);  // finish across the wrap
        send_levels(32'd5000,       3'b001, 3'b000);
        send_levels(32'd4000,       3'b010, 3'b001);  // stamp ahead of now: saturates
        send_levels(32'd4100,       3'b000, 3'b000);  // quiet: clear one, track two
        // Fill segment one to the brim; the last edge is dropped
        for (int i = 0; i <= DEPTH_ONE_DEF; i++) begin
            send_levels(32'd4200 + 32'(i) * 32'd10, 3'b001, 3'b000);
        end
        clock_ms  = 32'd4400;
        sensor_lv = 3'b001;

        // Zero ceiling: every time reads zero
        settle_then_write(32'd0);
        run_traffic(60, 50);

        // Widest ceiling, with sample time running through the wrap
        settle_then_write(32'hFFFF_FFFF);
        clock_ms = 32'hFFFF_FC00;
        run_traffic(80, 100);

        // Tight ceiling, so long transits saturate often
        settle_then_write(32'd500);
        run_traffic(100, 120);

        // Random ceiling, with one long report-side hold-off
        settle_then_write(32'($urandom_range(1, 100000)));
        hold_req = 1'b1;
        run_traffic(100, 5000);

        // Back to the reset ceiling, full rate on both sides
        settle_then_write(MAX_MS_RESET);
        gaps_off = 1'b1;
        run_traffic(100, 20000);

        stop_samples();
        while (!board.drained()) @(posedge aclk);
        repeat (2 * SETTLE_CYCLES) @(posedge aclk);

        if (board.fault_count == 0 && board.drained()) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/tstt_pkg.sv
hdl/tstt_fifo.sv
hdl/two_segment_transit_timer_unit.sv
sim/tb.sv
